FILE: hdl/omt_pkg.sv
// omt_pkg: shared types and constants for the order message tracker
// no dependencies
package omt_pkg;

  localparam int unsigned DefaultSlots = 1024;

  typedef enum logic [2:0] {
    CMD_SUBMIT = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_CONN   = 3'd2,
    CMD_DISC   = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    OC_NONE     = 4'd0,
    OC_STORED   = 4'd1,
    OC_BUSY     = 4'd2,
    OC_IGNORED  = 4'd3,
    OC_ACCEPTED = 4'd4,
    OC_PARTIAL  = 4'd5,
    OC_FILLED   = 4'd6,
    OC_REJECTED = 4'd7,
    OC_MALFORM  = 4'd8,
    OC_CONN     = 4'd9,
    OC_DISC     = 4'd10,
    OC_STALE    = 4'd11,
    OC_REPEAT   = 4'd12
  } outcome_e;

  localparam logic [7:0] KindSeq      = 8'h53; // 'S'
  localparam logic [7:0] KindAccepted = 8'h41; // 'A'
  localparam logic [7:0] KindExecuted = 8'h45; // 'E'
  localparam logic [7:0] KindRejected = 8'h4A; // 'J'
  localparam logic [7:0] KindHeart    = 8'h48; // 'H'
  localparam logic [16:0] MinSeqSize  = 17'd4;
  localparam logic [16:0] MinAckSize  = 17'd16;
  localparam logic [16:0] MinExecSize = 17'd20;

  // which statistic an item bumps
  typedef enum logic [8:0] {
    ST_NONE = 9'b000000000,
    ST_SENT = 9'b000000001,
    ST_ACC  = 9'b000000010,
    ST_FILL = 9'b000000100,
    ST_REJ  = 9'b000001000,
    ST_MAL  = 9'b000010000,
    ST_DROP = 9'b000100000,
    ST_CONN = 9'b001000000,
    ST_DISC = 9'b010000000
  } stat_e;

  typedef struct packed {
    logic   valid;
    stat_e  stat;
    logic   pend_inc;
    logic   pend_dec;
  } stat_upd_t;

endpackage

FILE: hdl/omt_stats.sv
// omt_stats: saturating statistics counters and the pending slot count
// depends on omt_pkg
module omt_stats import omt_pkg::*; #(
  parameter int unsigned PendW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stat_upd_t        upd_i,
  output logic [PendW-1:0] pending_o,
  output logic [7:0][31:0] count_o
);

  logic [7:0][31:0] cnt_q;
  logic [PendW-1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else if (upd_i.valid) begin
      for (int k = 0; k < 8; k++) begin
        if (upd_i.stat[k] && cnt_q[k] != 32'hFFFF_FFFF) begin
          cnt_q[k] <= cnt_q[k] + 32'd1;
        end
      end
      if (upd_i.pend_inc) begin
        pend_q <= pend_q + 1'b1;
      end else if (upd_i.pend_dec && pend_q != '0) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  assign pending_o = pend_q;
  assign count_o   = cnt_q;

endmodule

FILE: hdl/order_message_tracker_top.sv
// order_message_tracker_top: order table, link frame parser and statistics
// depends on omt_pkg and omt_stats
//
// Orders land in a direct-mapped table indexed by the low bits of their
// reference; link bytes are framed by a big-endian 16-bit length and the
// closing byte of a sequenced frame applies Accepted, Executed or Rejected to
// the matching slot. Each accepted beat yields one result beat with an
// outcome code, the reference concerned and all statistics. The table,
// including the valid and acked flags of every slot, sits in one synchronous
// memory with a registered read, so every item passes through a read cycle
// and a modify/write-back cycle that loads the output register. A stalled
// result holds the modify/write-back cycle, and with it the input. One item
// is in work at a time, so a table write always completes before the next
// read and needs no forwarding. After reset the table is cleared one entry
// per cycle, PENDING_SLOTS entries (1024 by default), while the input stalls.
module order_message_tracker_top import omt_pkg::*; #(
  parameter int unsigned PENDING_SLOTS = DefaultSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] order_ref_i,
  input  logic [31:0] order_shares_i,
  input  logic [31:0] link_gen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  outcome_o,
  output logic [31:0] ref_out_o,
  output logic [10:0] pending_count_o,
  output logic [31:0] sent_count_o,
  output logic [31:0] accepted_count_o,
  output logic [31:0] filled_count_o,
  output logic [31:0] rejected_count_o,
  output logic [31:0] malformed_count_o,
  output logic [31:0] drop_count_o,
  output logic [31:0] connect_count_o,
  output logic [31:0] disconnect_count_o
);

  localparam int unsigned IdxW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(PENDING_SLOTS + 1);
  localparam int unsigned PendW = (CntW > 11) ? CntW : 11;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PENDING_SLOTS - 1);

  typedef struct packed {
    logic        valid;
    logic        acked;
    logic [31:0] sref;
    logic [31:0] qty;
    logic [31:0] done;
  } slot_t;

  // control: clearing pass, then read, then modify and write back
  typedef enum logic [2:0] {
    PH_CLEAR = 3'b001,
    PH_IDLE  = 3'b010,
    PH_EXEC  = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  slot_t       mem [PENDING_SLOTS];
  slot_t       rd_q;
  logic [IdxW-1:0] clr_q;

  // captured item
  logic [2:0]  cmd_q;
  logic [7:0]  byte_q;
  logic [31:0] oref_q, oqty_q, gen_q;

  // parser state
  logic [31:0] cur_gen_q;
  logic [15:0] flen_q;
  logic [16:0] pos_q;
  logic [7:0]  fkind_q, mkind_q;
  logic [31:0] refc_q, qtyc_q;

  // output register
  logic        ovalid_q;
  logic [3:0]  outc_q;
  logic [31:0] oref_out_q;

  logic accept_in, out_free;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = (phase_q != PH_IDLE);
  assign accept_in  = in_valid_i && !in_stall_o;

  // read address: submit uses the order reference; a link byte uses the
  // reference as it stands after this byte, which may itself be its last byte
  logic [IdxW-1:0] rd_idx, ex_idx;
  logic [31:0]     rd_ref;
  always_comb begin
    if (cmd_i == CMD_SUBMIT) begin
      rd_ref = order_ref_i;
    end else if (pos_q >= 17'd12 && pos_q <= 17'd15) begin
      rd_ref = {refc_q[23:0], data_byte_i};
    end else begin
      rd_ref = refc_q;
    end
    rd_idx = rd_ref[IdxW-1:0] & LastIdx;
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      rd_q <= mem[rd_idx];
    end
  end

  // execute phase
  logic        ex_fire;
  logic [3:0]  outc_d;
  logic [31:0] refo_d;
  stat_upd_t   upd;
  logic        wr_en;
  slot_t       wr_data;
  logic [15:0] flen_d;
  logic [16:0] pos_d;
  logic [7:0]  fkind_d, mkind_d;
  logic [31:0] refc_d, qtyc_d, cur_gen_d;
  logic [16:0] size;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic        hit;

  assign ex_fire = (phase_q == PH_EXEC) && out_free;
  assign ex_idx  = ((cmd_q == CMD_SUBMIT) ? oref_q[IdxW-1:0] : refc_d[IdxW-1:0]) & LastIdx;
  assign size    = {1'b0, flen_q} + 17'd2;
  assign sum     = {1'b0, rd_q.done} + {1'b0, qtyc_d};
  assign sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign hit     = rd_q.valid && rd_q.sref == refc_d;

  always_comb begin
    outc_d    = OC_NONE;
    refo_d    = '0;
    upd       = '{valid: 1'b0, stat: ST_NONE, pend_inc: 1'b0, pend_dec: 1'b0};
    wr_en     = 1'b0;
    wr_data   = rd_q;
    flen_d    = flen_q;
    pos_d     = pos_q;
    fkind_d   = fkind_q;
    mkind_d   = mkind_q;
    refc_d    = refc_q;
    qtyc_d    = qtyc_q;
    cur_gen_d = cur_gen_q;
    case (cmd_q)
      CMD_SUBMIT: begin
        refo_d = oref_q;
        if (rd_q.valid) begin
          upd.stat = ST_DROP;
          outc_d   = OC_BUSY;
        end else begin
          upd.stat     = ST_SENT;
          upd.pend_inc = 1'b1;
          wr_en        = 1'b1;
          wr_data      = '{valid: 1'b1, acked: 1'b0, sref: oref_q, qty: oqty_q, done: '0};
          outc_d       = OC_STORED;
        end
      end
      CMD_BYTE: begin
        if (pos_q == 17'd0) begin
          flen_d = {byte_q, 8'h00};
          pos_d  = 17'd1;
        end else if (pos_q == 17'd1) begin
          flen_d = {flen_q[15:8], byte_q};
          if (flen_d == 16'd0) begin
            pos_d    = 17'd0;
            upd.stat = ST_MAL;
            outc_d   = OC_MALFORM;
          end else begin
            pos_d   = 17'd2;
            fkind_d = '0;
            mkind_d = '0;
            refc_d  = '0;
            qtyc_d  = '0;
          end
        end else begin
          if (pos_q == 17'd2) begin
            fkind_d = byte_q;
          end else if (pos_q == 17'd3) begin
            mkind_d = byte_q;
          end else if (pos_q >= 17'd12 && pos_q <= 17'd15) begin
            refc_d = {refc_q[23:0], byte_q};
          end else if (pos_q >= 17'd16 && pos_q <= 17'd19) begin
            qtyc_d = {qtyc_q[23:0], byte_q};
          end
          if (pos_q == {1'b0, flen_q} + 17'd1) begin
            pos_d = 17'd0;
            // frame close, fields include the closing byte
            if (fkind_d == KindAccepted || fkind_d == KindHeart ||
                fkind_d == KindRejected) begin
              outc_d = OC_IGNORED;
            end else if (fkind_d != KindSeq || size < MinSeqSize ||
                         (mkind_d != KindAccepted && mkind_d != KindExecuted &&
                          mkind_d != KindRejected) ||
                         size < ((mkind_d == KindExecuted) ? MinExecSize
                                                            : MinAckSize)) begin
              upd.stat = ST_MAL;
              outc_d   = OC_MALFORM;
            end else begin
              refo_d = refc_d;
              if (!hit) begin
                upd.stat = ST_MAL;
                outc_d   = OC_MALFORM;
              end else if (mkind_d == KindAccepted) begin
                if (rd_q.acked) begin
                  outc_d = OC_REPEAT;
                end else begin
                  wr_en         = 1'b1;
                  wr_data.acked = 1'b1;
                  upd.stat      = ST_ACC;
                  outc_d        = OC_ACCEPTED;
                end
              end else if (mkind_d == KindExecuted) begin
                wr_en        = 1'b1;
                wr_data.done = sum_sat;
                if (sum_sat >= rd_q.qty) begin
                  upd.stat      = ST_FILL;
                  upd.pend_dec  = 1'b1;
                  wr_data.valid = 1'b0;
                  wr_data.acked = 1'b0;
                  outc_d        = OC_FILLED;
                end else begin
                  outc_d = OC_PARTIAL;
                end
              end else begin
                upd.stat      = ST_REJ;
                upd.pend_dec  = 1'b1;
                wr_en         = 1'b1;
                wr_data.valid = 1'b0;
                wr_data.acked = 1'b0;
                outc_d        = OC_REJECTED;
              end
            end
          end else begin
            pos_d = pos_q + 17'd1;
          end
        end
      end
      CMD_CONN: begin
        cur_gen_d = gen_q;
        pos_d     = '0;
        flen_d    = '0;
        upd.stat  = ST_CONN;
        outc_d    = OC_CONN;
      end
      CMD_DISC, CMD_CLOSE: begin
        if (cmd_q == CMD_DISC && gen_q != cur_gen_q) begin
          outc_d = OC_STALE;
        end else begin
          cur_gen_d = '0;
          pos_d     = '0;
          flen_d    = '0;
          upd.stat  = ST_DISC;
          outc_d    = OC_DISC;
        end
      end
      default: begin
        outc_d = OC_NONE;
      end
    endcase
    upd.valid = ex_fire;
  end

  // single write port: clearing pass after reset, then write-back
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_CLEAR) begin
      mem[clr_q] <= '0;
    end else if (ex_fire && wr_en) begin
      mem[ex_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q  <= cmd_i;
      byte_q <= data_byte_i;
      oref_q <= order_ref_i;
      oqty_q <= order_shares_i;
      gen_q  <= link_gen_i;
    end
    if (ex_fire) begin
      outc_q     <= outc_d;
      oref_out_q <= refo_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_CLEAR: if (clr_q == LastIdx) phase_d = PH_IDLE;
      PH_IDLE:  if (accept_in) phase_d = PH_EXEC;
      PH_EXEC:  if (ex_fire) phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CLEAR;
      clr_q     <= '0;
      ovalid_q  <= 1'b0;
      cur_gen_q <= '0;
      flen_q    <= '0;
      pos_q     <= '0;
      fkind_q   <= '0;
      mkind_q   <= '0;
      refc_q    <= '0;
      qtyc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == PH_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ex_fire) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      if (ex_fire) begin
        cur_gen_q <= cur_gen_d;
        flen_q    <= flen_d;
        pos_q     <= pos_d;
        fkind_q   <= fkind_d;
        mkind_q   <= mkind_d;
        refc_q    <= refc_d;
        qtyc_q    <= qtyc_d;
      end
    end
  end

  logic [PendW-1:0] pend;
  logic [7:0][31:0] cnt;

  omt_stats #(.PendW(PendW)) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .pending_o (pend),
    .count_o   (cnt)
  );

  // counters move with the result register, so outputs stay consistent
  assign pending_count_o    = pend[10:0];
  assign out_valid_o        = ovalid_q;
  assign outcome_o          = outc_q;
  assign ref_out_o          = oref_out_q;
  assign sent_count_o       = cnt[0];
  assign accepted_count_o   = cnt[1];
  assign filled_count_o     = cnt[2];
  assign rejected_count_o   = cnt[3];
  assign malformed_count_o  = cnt[4];
  assign drop_count_o       = cnt[5];
  assign connect_count_o    = cnt[6];
  assign disconnect_count_o = cnt[7];

endmodule

FILE: verif/order_message_tracker_chk.sv
// order_message_tracker_chk: watches both channels of the order message tracker,
// predicts each result beat and compares it field by field
// depends on omt_pkg
`timescale 1ns / 1ps
module order_message_tracker_chk import omt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] order_ref_i,
  input  logic [31:0] order_shares_i,
  input  logic [31:0] link_gen_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  outcome_i,
  input  logic [31:0] ref_out_i,
  input  logic [10:0] pending_count_i,
  input  logic [31:0] sent_count_i,
  input  logic [31:0] accepted_count_i,
  input  logic [31:0] filled_count_i,
  input  logic [31:0] rejected_count_i,
  input  logic [31:0] malformed_count_i,
  input  logic [31:0] drop_count_i,
  input  logic [31:0] connect_count_i,
  input  logic [31:0] disconnect_count_i,
  output int          fail_count_o,
  output int          backlog_o
);

  localparam int unsigned Slots = DefaultSlots;
  localparam int NumStats = 8;
  localparam int IdxSent = 0;
  localparam int IdxAcc = 1;
  localparam int IdxFill = 2;
  localparam int IdxRej = 3;
  localparam int IdxMal = 4;
  localparam int IdxDrop = 5;
  localparam int IdxConn = 6;
  localparam int IdxDisc = 7;

  typedef struct {
    outcome_e    outcome;
    logic [31:0] ref_no;
    logic [10:0] pending;
    logic [31:0] stats[NumStats];
  } tracker_result_t;

  bit          busy_q[Slots];
  bit          acked_q[Slots];
  logic [31:0] ref_tbl[Slots];
  logic [31:0] qty_tbl[Slots];
  logic [31:0] done_tbl[Slots];
  logic [31:0] gen_q;
  logic [15:0] len_q;
  logic [16:0] pos_q;
  logic [7:0]  frame_kind_q;
  logic [7:0]  msg_kind_q;
  logic [31:0] ref_cap_q;
  logic [31:0] qty_cap_q;
  logic [31:0] stats_q[NumStats];
  logic [31:0] pending_q;
  tracker_result_t result_queue[$];

  function automatic void bump(int k);
    if (stats_q[k] != 32'hFFFF_FFFF) stats_q[k]++;
  endfunction

  function automatic void free_slot(int unsigned i);
    busy_q[i] = 0;
    acked_q[i] = 0;
    if (pending_q != 0) pending_q--;
  endfunction

  // end of a frame: act on what was captured on the way
  function automatic outcome_e close_frame(output logic [31:0] r);
    logic [16:0] size;
    int unsigned i;
    logic [32:0] sum;
    size = {1'b0, len_q} + 17'd2;
    i = ref_cap_q % Slots;
    r = '0;
    if (frame_kind_q inside {KindAccepted, KindHeart, KindRejected}) return OC_IGNORED;
    if (frame_kind_q != KindSeq || size < MinSeqSize ||
        !(msg_kind_q inside {KindAccepted, KindExecuted, KindRejected}) ||
        size < (msg_kind_q == KindExecuted ? MinExecSize : MinAckSize)) begin
      bump(IdxMal);
      return OC_MALFORM;
    end
    r = ref_cap_q;
    if (!busy_q[i] || ref_tbl[i] != ref_cap_q) begin
      bump(IdxMal);
      return OC_MALFORM;
    end
    if (msg_kind_q == KindAccepted) begin
      if (acked_q[i]) return OC_REPEAT;
      acked_q[i] = 1;
      bump(IdxAcc);
      return OC_ACCEPTED;
    end
    if (msg_kind_q == KindExecuted) begin
      sum = done_tbl[i] + qty_cap_q;
      done_tbl[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (done_tbl[i] >= qty_tbl[i]) begin
        bump(IdxFill);
        free_slot(i);
        return OC_FILLED;
      end
      return OC_PARTIAL;
    end
    bump(IdxRej);
    free_slot(i);
    return OC_REJECTED;
  endfunction

  function automatic outcome_e parse_byte(logic [7:0] b, output logic [31:0] r);
    r = '0;
    if (pos_q == 0) begin
      len_q = {b, 8'h00};
      pos_q = 1;
      return OC_NONE;
    end
    if (pos_q == 1) begin
      len_q[7:0] = b;
      if (len_q == 0) begin
        pos_q = 0;
        bump(IdxMal);
        return OC_MALFORM;
      end
      pos_q = 2;
      frame_kind_q = '0;
      msg_kind_q = '0;
      ref_cap_q = '0;
      qty_cap_q = '0;
      return OC_NONE;
    end
    if (pos_q == 2) frame_kind_q = b;
    else if (pos_q == 3) msg_kind_q = b;
    else if (pos_q >= 12 && pos_q <= 15) ref_cap_q = {ref_cap_q[23:0], b};
    else if (pos_q >= 16 && pos_q <= 19) qty_cap_q = {qty_cap_q[23:0], b};
    if (pos_q == {1'b0, len_q} + 17'd1) begin
      pos_q = 0;
      return close_frame(r);
    end
    pos_q++;
    return OC_NONE;
  endfunction

  function automatic tracker_result_t track_item(logic [2:0] cmd, logic [7:0] b,
                                                 logic [31:0] oref, logic [31:0] oqty,
                                                 logic [31:0] gen);
    tracker_result_t res;
    int unsigned i;
    res.outcome = OC_NONE;
    res.ref_no = '0;
    i = oref % Slots;
    case (cmd)
      CMD_SUBMIT: begin
        res.ref_no = oref;
        if (busy_q[i]) begin
          bump(IdxDrop);
          res.outcome = OC_BUSY;
        end else begin
          bump(IdxSent);
          busy_q[i] = 1;
          acked_q[i] = 0;
          ref_tbl[i] = oref;
          qty_tbl[i] = oqty;
          done_tbl[i] = '0;
          pending_q++;
          res.outcome = OC_STORED;
        end
      end
      CMD_BYTE: res.outcome = parse_byte(b, res.ref_no);
      CMD_CONN: begin
        gen_q = gen;
        pos_q = 0;
        len_q = 0;
        bump(IdxConn);
        res.outcome = OC_CONN;
      end
      CMD_DISC, CMD_CLOSE: begin
        if (cmd == CMD_DISC && gen != gen_q) begin
          res.outcome = OC_STALE;
        end else begin
          gen_q = '0;
          pos_q = 0;
          len_q = 0;
          bump(IdxDisc);
          res.outcome = OC_DISC;
        end
      end
      default: ;
    endcase
    res.pending = pending_q[10:0];
    res.stats = stats_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tracker_result_t want;
    logic [31:0] got[NumStats];
    if (!rst_ni) begin
      foreach (busy_q[k]) begin
        busy_q[k] = 0;
        acked_q[k] = 0;
      end
      foreach (stats_q[k]) stats_q[k] = '0;
      gen_q = '0; len_q = '0; pos_q = '0; frame_kind_q = '0; msg_kind_q = '0;
      ref_cap_q = '0; qty_cap_q = '0; pending_q = '0;
      result_queue.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count_o++;
        end else begin
          want = result_queue.pop_front();
          got = '{sent_count_i, accepted_count_i, filled_count_i, rejected_count_i,
                  malformed_count_i, drop_count_i, connect_count_i, disconnect_count_i};
          check_field("outcome", want.outcome, outcome_i);
          check_field("ref_out", want.ref_no, ref_out_i);
          check_field("pending_count", want.pending, pending_count_i);
          check_field("sent_count", want.stats[IdxSent], got[IdxSent]);
          check_field("accepted_count", want.stats[IdxAcc], got[IdxAcc]);
          check_field("filled_count", want.stats[IdxFill], got[IdxFill]);
          check_field("rejected_count", want.stats[IdxRej], got[IdxRej]);
          check_field("malformed_count", want.stats[IdxMal], got[IdxMal]);
          check_field("drop_count", want.stats[IdxDrop], got[IdxDrop]);
          check_field("connect_count", want.stats[IdxConn], got[IdxConn]);
          check_field("disconnect_count", want.stats[IdxDisc], got[IdxDisc]);
        end
      end
      if (in_valid_i && !in_stall_i)
        result_queue.push_back(track_item(cmd_i, data_byte_i, order_ref_i,
                                          order_shares_i, link_gen_i));
    end
    backlog_o = result_queue.size();
  end

endmodule

FILE: verif/order_message_tracker_top_tb.sv
// order_message_tracker_top_tb: stimulus and verdict for the order message tracker
// depends on omt_pkg, order_message_tracker_top and order_message_tracker_chk
`timescale 1ns / 1ps
module order_message_tracker_top_tb;
  import omt_pkg::*;

  localparam int RandomItems = 720;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [31:0] order_ref_i = '0;
  logic [31:0] order_shares_i = '0;
  logic [31:0] link_gen_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [3:0]  outcome_o;
  logic [31:0] ref_out_o;
  logic [10:0] pending_count_o;
  logic [31:0] sent_count_o, accepted_count_o, filled_count_o, rejected_count_o;
  logic [31:0] malformed_count_o, drop_count_o, connect_count_o, disconnect_count_o;
  int          fail_count;
  int          backlog;
  int          cycle_count = 0;
  bit          calm_phase = 1'b0;  // no idling on either side
  bit          hold_off = 1'b0;    // receiver holds off so the block backs up

  // refs recently stored, so acks usually hit a live slot
  logic [31:0] live_refs[$];
  // beats that the sender still has to offer
  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  b;
    logic [31:0] oref;
    logic [31:0] oqty;
    logic [31:0] gen;
  } beat_t;
  beat_t beat_queue[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  order_message_tracker_top dut (.*);

  order_message_tracker_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .data_byte_i,
    .order_ref_i, .order_shares_i, .link_gen_i, .out_valid_i(out_valid_o), .out_stall_i,
    .outcome_i(outcome_o), .ref_out_i(ref_out_o), .pending_count_i(pending_count_o),
    .sent_count_i(sent_count_o), .accepted_count_i(accepted_count_o),
    .filled_count_i(filled_count_o), .rejected_count_i(rejected_count_o),
    .malformed_count_i(malformed_count_o), .drop_count_i(drop_count_o),
    .connect_count_i(connect_count_o), .disconnect_count_i(disconnect_count_o),
    .fail_count_o(fail_count), .backlog_o(backlog)
  );

  // cycle counter: a hung run fails here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, none in the calm phase, solid during hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b1;
    else out_stall_i <= hold_off || (!calm_phase && $urandom_range(99) < 25);
  end

  // long hold-off in its own process, counted in cycles
  initial begin
    wait (cycle_count == 2000);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic add_beat(logic [2:0] cmd, logic [7:0] b, logic [31:0] oref,
                          logic [31:0] oqty, logic [31:0] gen);
    beat_t bt;
    bt = '{cmd, b, oref, oqty, gen};
    beat_queue.push_back(bt);
  endtask

  task automatic add_byte(logic [7:0] b);
    add_beat(CMD_BYTE, b, $urandom, $urandom, $urandom);
  endtask

  task automatic add_order(logic [31:0] oref, logic [31:0] oqty);
    add_beat(CMD_SUBMIT, $urandom, oref, oqty, $urandom);
    live_refs.push_back(oref);
    if (live_refs.size() > 16) void'(live_refs.pop_front());
  endtask

  // one link frame: length header, frame kind, message kind, padding,
  // reference at bytes 12..15 and shares at 16..19 of the frame
  task automatic add_frame(logic [15:0] len, logic [7:0] fkind, logic [7:0] mkind,
                           logic [31:0] oref, logic [31:0] qty);
    logic [7:0] b;
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int p = 2; p <= int'(len) + 1; p++) begin
      b = $urandom;
      if (p == 2) b = fkind;
      else if (p == 3) b = mkind;
      else if (p >= 12 && p <= 15) b = oref[8 * (15 - p) +: 8];
      else if (p >= 16 && p <= 19) b = qty[8 * (19 - p) +: 8];
      add_byte(b);
    end
  endtask

  function automatic logic [31:0] pick_ref();
    if (live_refs.size() == 0 || $urandom_range(9) == 0) return $urandom_range(63);
    return live_refs[$urandom_range(live_refs.size() - 1)];
  endfunction

  // one random well-formed or broken sequence, mostly aimed at live orders
  task automatic add_random_step();
    int pick;
    logic [15:0] len;
    logic [7:0] mk;
    logic [31:0] r;
    logic [31:0] g;
    pick = $urandom_range(99);
    r = pick_ref();
    len = $urandom_range(1) ? 16'd14 : 16'd18 + $urandom_range(3);
    if (pick < 30) begin
      // small refs keep collisions frequent; sometimes huge values
      add_order($urandom_range(1) ? $urandom_range(2047) : $urandom,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 40));
    end else if (pick < 45) begin
      add_frame(len, KindSeq, KindAccepted, r, $urandom);
    end else if (pick < 65) begin
      add_frame(16'd18 + $urandom_range(2), KindSeq, KindExecuted, r,
                $urandom_range(7) == 0 ? $urandom : $urandom_range(1, 20));
    end else if (pick < 73) begin
      add_frame(len, KindSeq, KindRejected, r, $urandom);
    end else if (pick < 78) begin
      mk = $urandom_range(1) ? KindHeart : KindRejected;
      add_frame($urandom_range(0, 6), $urandom_range(1) ? mk : 8'($urandom),
                8'($urandom), r, $urandom);
    end else if (pick < 84) begin
      // short or unknown message
      add_frame($urandom_range(1, 17), KindSeq,
                $urandom_range(1) ? KindExecuted : 8'($urandom), r, $urandom);
    end else if (pick < 88) begin
      g = $urandom;
      add_beat(CMD_CONN, $urandom, $urandom, $urandom, g);
      add_beat(CMD_DISC, $urandom, $urandom, $urandom, $urandom_range(1) ? g : $urandom);
    end else if (pick < 92) begin
      // partial frame cut by a link event
      add_byte(8'h00);
      add_byte(8'd30);
      repeat ($urandom_range(0, 5)) add_byte($urandom);
      add_beat($urandom_range(CMD_CONN, CMD_CLOSE), $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 96) begin
      add_byte($urandom);
    end else begin
      add_beat($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // offer every queued beat, with random gaps outside the calm phase
  task automatic send_queued();
    beat_t bt;
    while (beat_queue.size() != 0) begin
      bt = beat_queue.pop_front();
      while (!calm_phase && !hold_off && $urandom_range(99) < 25) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      cmd_i <= bt.cmd;
      data_byte_i <= bt.b;
      order_ref_i <= bt.oref;
      order_shares_i <= bt.oqty;
      link_gen_i <= bt.gen;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every command, and the special cases
    add_order(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_order(32'h0000_03FF, 32'd5);             // same slot: busy
    add_order(32'd0, 32'd0);
    add_byte(8'h00);
    add_byte(8'h00);                             // zero length frame
    add_frame(16'd1, KindHeart, 8'h00, 32'd0, 32'd0);       // ignored frame
    add_frame(16'd1, KindSeq, 8'h00, 32'd0, 32'd0);         // sequenced too short
    add_frame(16'd14, KindSeq, KindAccepted, 32'hFFFF_FFFF, 32'd0);
    add_frame(16'd14, KindSeq, KindAccepted, 32'hFFFF_FFFF, 32'd0); // repeat accept
    add_frame(16'd18, KindSeq, KindExecuted, 32'hFFFF_FFFF, 32'hFFFF_FFF0); // partial
    add_frame(16'd18, KindSeq, KindExecuted, 32'hFFFF_FFFF, 32'hFFFF_FFF0); // saturates
    add_frame(16'd17, KindSeq, KindExecuted, 32'd0, 32'd1); // short executed
    add_frame(16'd13, KindSeq, KindRejected, 32'd0, 32'd0); // short reject
    add_frame(16'd14, KindSeq, 8'h5A, 32'd0, 32'd0);        // unknown message
    add_frame(16'd14, KindSeq, KindAccepted, 32'd77, 32'd0); // no matching slot
    add_frame(16'd14, KindSeq, KindRejected, 32'd0, 32'd0);
    add_frame(16'd2, 8'hFF, 8'h00, 32'd0, 32'd0);           // unknown frame type
    add_beat(CMD_CONN, 8'h00, '0, '0, 32'hFFFF_FFFF);
    add_beat(CMD_DISC, 8'h00, '0, '0, 32'd1);               // stale disconnect
    add_beat(CMD_DISC, 8'h00, '0, '0, 32'hFFFF_FFFF);
    add_beat(CMD_CLOSE, 8'hFF, '1, '1, '1);
    add_beat(3'd7, 8'hFF, '1, '1, '1);
    send_queued();

    // random part, one calm stretch in the middle
    for (int n = 0; n < RandomItems; ) begin
      calm_phase = (n > 300 && n < 450);
      add_random_step();
      n += beat_queue.size();
      send_queued();
    end
    calm_phase = 1'b0;

    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: order_message_tracker_top.f
hdl/omt_pkg.sv
hdl/omt_stats.sv
hdl/order_message_tracker_top.sv
verif/order_message_tracker_chk.sv
verif/order_message_tracker_top_tb.sv
